>>> rtl/skinny64_block_cipher_defines.svh
// Assertion macros for the checker module.
`ifndef SKINNY64_BLOCK_CIPHER_DEFINES_SVH
`define SKINNY64_BLOCK_CIPHER_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define SK64_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sk64 check failed");

// Consequent checked in the same cycle as the antecedent.
`define SK64_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sk64 check failed");

`endif

>>> rtl/sk64_pkg.sv
package sk64_pkg;

  localparam int BLOCK_W        = 64;
  localparam int ROUND_KEY_W    = 32;
  localparam int DEF_MAX_ROUNDS = 40;
  localparam int REG_IDX_W      = 3;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_TK_ONE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TK_TWO    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TK_THREE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TK_COUNT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TWEAK_EN  = 3'd4;

  // Round counts for one, two and three tweakey words
  localparam logic [5:0] ROUNDS_ONE_WORD   = 6'd32;
  localparam logic [5:0] ROUNDS_TWO_WORDS  = 6'd36;
  localparam logic [5:0] ROUNDS_THREE_WORDS = 6'd40;

  localparam logic [BLOCK_W-1:0] ROUND_CONST = 64'h0000_0020_0000_0000;
  localparam logic [15:0]        TWEAK_BIT   = 16'h2000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BUILD,
    ST_RUN,
    ST_DRAIN
  } sk64_state_t;

  function automatic logic [63:0] sbox_fwd(input logic [63:0] x);
    logic [63:0] b0, b1, b2, b3;
    b0 = x;
    b1 = x >> 1;
    b2 = x >> 2;
    b3 = x >> 3;
    b0 = b0 ^ ~(b3 | b2);
    b3 = b3 ^ ~(b1 | b2);
    b2 = b2 ^ ~(b1 | b0);
    b1 = b1 ^ ~(b0 | b3);
    return ((b0 << 3) & 64'h8888_8888_8888_8888) | (b1 & 64'h1111_1111_1111_1111) |
           ((b2 << 1) & 64'h2222_2222_2222_2222) | ((b3 << 2) & 64'h4444_4444_4444_4444);
  endfunction

  function automatic logic [63:0] sbox_inv(input logic [63:0] x);
    logic [63:0] b0, b1, b2, b3;
    b0 = x;
    b1 = x >> 1;
    b2 = x >> 2;
    b3 = x >> 3;
    b0 = b0 ^ ~(b3 | b2);
    b1 = b1 ^ ~(b3 | b0);
    b2 = b2 ^ ~(b1 | b0);
    b3 = b3 ^ ~(b1 | b2);
    return ((b0 << 1) & 64'h2222_2222_2222_2222) | ((b1 << 2) & 64'h4444_4444_4444_4444) |
           ((b2 << 3) & 64'h8888_8888_8888_8888) | (b3 & 64'h1111_1111_1111_1111);
  endfunction

  function automatic logic [63:0] add_key(input logic [63:0] s, input logic [31:0] sk);
    return s ^ {32'h0, sk} ^ ROUND_CONST;
  endfunction

  function automatic logic [63:0] enc_round(input logic [63:0] s, input logic [31:0] sk);
    logic [63:0] x;
    logic [15:0] r0, r1, r2, r3;
    x  = add_key(sbox_fwd(s), sk);
    r0 = x[15:0];
    r1 = {x[19:16], x[31:20]};   // rotate right 4
    r2 = {x[39:32], x[47:40]};   // rotate right 8
    r3 = {x[59:48], x[63:60]};   // rotate right 12
    r1 = r1 ^ r2;
    r2 = r2 ^ r0;
    return {r2, r1, r0, r3 ^ r2};
  endfunction

  function automatic logic [63:0] dec_round(input logic [63:0] s, input logic [31:0] sk);
    logic [15:0] a, b, c, d, n1, n2, n3;
    a  = s[15:0];
    b  = s[31:16];
    c  = s[47:32];
    d  = s[63:48];
    n3 = a ^ d;
    n2 = d ^ b;
    n1 = c ^ n2;
    n1 = {n1[11:0], n1[15:12]};  // rotate right 12
    n2 = {n2[7:0], n2[15:8]};    // rotate right 8
    n3 = {n3[3:0], n3[15:4]};    // rotate right 4
    return sbox_inv(add_key({n3, n2, n1, b}, sk));
  endfunction

  function automatic logic [63:0] tk_permute(input logic [63:0] t);
    logic [15:0] a, b, r0, r1;
    a  = t[47:32];
    b  = {t[55:48], t[63:56]};
    r0 = ((a << 4) & 16'h00F0) | ((a << 8) & 16'hF000) | (b & 16'h0F0F);
    r1 = ((a >> 8) & 16'h00F0) | (a & 16'h0F00) | ((b >> 4) & 16'h000F) | (b & 16'hF000);
    return {t[31:16], t[15:0], r1, r0};
  endfunction

  function automatic logic [31:0] lfsr_two(input logic [31:0] x);
    return ((x << 1) & 32'hEEEE_EEEE) ^ (((x >> 3) ^ (x >> 2)) & 32'h1111_1111);
  endfunction

  function automatic logic [31:0] lfsr_three(input logic [31:0] x);
    return ((x >> 1) & 32'h7777_7777) ^ ((x ^ (x << 3)) & 32'h8888_8888);
  endfunction

endpackage

>>> rtl/sk64_ram.sv
module sk64_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/skinny64_block_cipher.sv
// SKINNY-64 block cipher, ECB mode, round-iterative. Each input transaction
// carries a 64-bit block (bytes little-endian, row r in bits 16r+15..16r) and
// a direction (func: 0 encrypt, 1 decrypt); each yields one output transaction
// with the result block. Configuration registers: 0 tk_one, 1 tk_two,
// 2 tk_three, 3 tk_count (1..3 words, 0 acts as 1), 4 tweak_enable; indexes
// 5 and up are ignored. Every accepted write rebuilds the round-subkey store:
// one subkey per cycle into a single-port-write RAM after a setup state, so
// the rebuild writes 32, 36 or 40 subkeys (capped at MAX_ROUNDS), during which
// in_stall is high. The store is not cleared at reset: write the configuration
// at least once before sending blocks. A block runs 32, 36 or 40 rounds
// between acceptance and out_valid: the first subkey is read from the store
// at the accepting edge, then one round runs per cycle, each round consuming
// the subkey read in the cycle before. One block is processed at a time; the
// input is free again once the last round's result is in the output register,
// so no block is taken before the last one is through. The output register
// lets the next block enter while a result waits, and a finished result is
// parked in the state register if out_stall is still high.
module skinny64_block_cipher
  import sk64_pkg::*;
#(
  parameter int MAX_ROUNDS = DEF_MAX_ROUNDS
) (
  input  logic                 clk,
  input  logic                 rst,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [BLOCK_W-1:0]   block_in,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BLOCK_W-1:0]   block_out,
  // configuration write port
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [BLOCK_W-1:0]   wr_data
);

  localparam int AW = $clog2(MAX_ROUNDS);      // subkey store address
  localparam int RW = $clog2(MAX_ROUNDS + 1);  // round count

  // configuration registers
  logic [63:0] tk_one, tk_two, tk_three;
  logic [1:0]  tk_count;
  logic        tweak_enable;

  sk64_state_t state, state_next;
  logic [RW-1:0] step;
  logic [RW-1:0] rounds;
  logic [5:0]    rounds_raw;

  // key schedule working registers
  logic [63:0] t1, t2, t3;
  logic [5:0]  rc;
  logic [5:0]  rc_next;
  logic [31:0] sk;
  logic [63:0] t2p, t3p;

  // cipher datapath
  logic [63:0] s;
  logic        dir;
  logic [63:0] round_res;
  logic [31:0] ram_rdata;

  // control decode
  logic          cfg_hit;
  logic          accept;
  logic          last;
  logic          out_free;
  logic          out_load;
  logic          ram_we;
  logic [RW-1:0] rd_step;

  // Round count from the number of tweakey words, capped at MAX_ROUNDS.
  always_comb begin
    case (tk_count)
      2'd2:    rounds_raw = ROUNDS_TWO_WORDS;
      2'd3:    rounds_raw = ROUNDS_THREE_WORDS;
      default: rounds_raw = ROUNDS_ONE_WORD;
    endcase
  end

  assign rounds = (int'(rounds_raw) > MAX_ROUNDS) ? RW'(MAX_ROUNDS) : RW'(rounds_raw);
  assign last   = (step == rounds - RW'(1));

  assign cfg_hit  = wr_en && (wr_index <= REG_TWEAK_EN);
  assign out_free = !out_valid || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tk_one       <= '0;
      tk_two       <= '0;
      tk_three     <= '0;
      tk_count     <= 2'd1;
      tweak_enable <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_TK_ONE:   tk_one       <= wr_data;
        REG_TK_TWO:   tk_two       <= wr_data;
        REG_TK_THREE: tk_three     <= wr_data;
        REG_TK_COUNT: tk_count     <= wr_data[1:0];
        REG_TWEAK_EN: tweak_enable <= wr_data[0];
        default:      ;
      endcase
    end
  end

  // Subkey for the current schedule step. The 6-bit round constant LFSR
  // advances first; its low nibble lands in row 0, its top two bits in row 1.
  assign rc_next = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};

  always_comb begin
    sk = t1[31:0];
    if (tk_count[1]) begin
      sk = sk ^ t2[31:0];
    end
    if (tk_count == 2'd3) begin
      sk = sk ^ t3[31:0];
    end
    sk = sk ^ {24'h0, rc_next[3:0], 4'h0} ^ {10'h0, rc_next[5:4], 20'h0};
    if (tweak_enable) begin
      sk = sk ^ {16'h0, TWEAK_BIT};
    end
  end

  assign t2p = tk_permute(t2);
  assign t3p = tk_permute(t3);

  assign round_res = dir ? dec_round(s, ram_rdata) : enc_round(s, ram_rdata);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_RUN;
      ST_LOAD:  state_next = ST_BUILD;
      ST_BUILD: if (last) state_next = ST_IDLE;
      ST_RUN: begin
        if (last) begin
          state_next = out_free ? ST_IDLE : ST_DRAIN;
        end
      end
      ST_DRAIN: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
    // any accepted register write restarts the schedule build
    if (cfg_hit) begin
      state_next = ST_LOAD;
    end
  end

  // Control outputs
  always_comb begin
    in_stall = 1'b1;
    ram_we   = 1'b0;
    out_load = 1'b0;
    rd_step  = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_step  = func ? rounds - RW'(1) : '0;
      end
      ST_BUILD: ram_we = 1'b1;
      ST_RUN: begin
        out_load = last && out_free;
        if (!last) begin
          rd_step = dir ? rounds - RW'(2) - step : step + RW'(1);
        end
      end
      ST_DRAIN: out_load = out_free;
      default:  ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_BUILD || state == ST_RUN) begin
        step <= step + RW'(1);
      end else begin
        step <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          s   <= block_in;
          dir <= func;
        end
      end
      ST_LOAD: begin
        t1 <= tk_one;
        t2 <= tk_two;
        t3 <= tk_three;
        rc <= '0;
      end
      ST_BUILD: begin
        t1 <= tk_permute(t1);
        t2 <= {t2p[63:32], lfsr_two(t2p[31:0])};
        t3 <= {t3p[63:32], lfsr_three(t3p[31:0])};
        rc <= rc_next;
      end
      ST_RUN:   s <= round_res;
      default:  ;
    endcase
    if (out_load) begin
      block_out <= (state == ST_DRAIN) ? s : round_res;
    end
  end

  // Round-subkey store: entry i holds rows 0 and 1 of the subkey of round i.
  sk64_ram #(
    .WIDTH (ROUND_KEY_W),
    .DEPTH (MAX_ROUNDS)
  ) u_key_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (step[AW-1:0]),
    .wdata (sk),
    .raddr (rd_step[AW-1:0]),
    .rdata (ram_rdata)
  );

endmodule

>>> rtl/sk64_checker.sv
`include "skinny64_block_cipher_defines.svh"

module sk64_checker
  import sk64_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [BLOCK_W-1:0]   block_out,
  input logic                 wr_en,
  input logic [REG_IDX_W-1:0] wr_index
);

  // a stalled result holds
  `SK64_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(block_out))

  // one block in flight: the transaction after acceptance is stalled
  `SK64_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall)

  // a register write starts a schedule rebuild that blocks input
  `SK64_ASSERT_NEXT(a_rebuild_stall, clk, rst, wr_en && (wr_index <= REG_TWEAK_EN), in_stall)

  // no result appears right after a block is taken
  `SK64_ASSERT_NEXT(a_min_latency, clk, rst, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind skinny64_block_cipher sk64_checker u_sk64_checker (.*);
